[rtl/core/assert_macros.svh]
// Assertion macros shared by the oscillator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

[rtl/core/mwo_pkg.sv]
// Shared types, constants and the sine table generator of the oscillator.
`timescale 1ns / 1ps

package mwo_pkg;

  localparam int SampleRateDef = 44100;
  localparam int SineDepthDef  = 1024;

  localparam int OneQ16 = 65536;
  localparam logic [31:0] LfsrTaps = 32'h8020_0003;
  localparam logic [31:0] LfsrSeed = 32'h0000_ACE1;
  // pi/2 in Q30.
  localparam longint unsigned PiHalfQ30 = 64'd1686629713;

  localparam int CfgAddrW = 1;
  localparam int CfgDataW = 3;
  localparam logic [CfgAddrW-1:0] CfgWaveMode = 1'd0;
  localparam logic [CfgAddrW-1:0] CfgPhaseExt = 1'd1;

  typedef enum logic [2:0] {
    WaveRamp  = 3'd0,
    WaveSine  = 3'd1,
    WaveSaw   = 3'd2,
    WavePulse = 3'd3,
    WaveNoise = 3'd4
  } wave_e;

  typedef struct packed {
    logic [2:0] wave_mode;
    logic       phase_ext;
  } mwo_cfg_t;

  typedef struct packed {
    logic               valid;
    logic signed [23:0] freq;
    logic signed [23:0] phase;
  } mwo_in_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] inc;
    logic [16:0] phase;
  } mwo_inc_t;

  typedef struct packed {
    logic               valid;
    logic signed [17:0] sample;
  } mwo_res_t;

  // sin(x) for x in Q30 within the first quadrant, by a seven-term series; Q16 result.
  function automatic logic [16:0] sine_q16(longint unsigned x);
    longint unsigned sum;
    longint unsigned term;
    sum  = x;
    term = x;
    for (int n = 1; n <= 6; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      case (n)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        default: term = term / 64'd156;
      endcase
      if (n % 2 == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    sum = (sum + 64'd8192) >> 14;
    if (sum > 64'd65536) begin
      sum = 64'd65536;
    end
    return sum[16:0];
  endfunction

endpackage

[rtl/core/multi_waveform_oscillator_unit.sv]
// Top level of the multi-waveform oscillator: config registers, input stage, output skid.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Numerically controlled oscillator producing one signed Q1.16 sample (phase ramp,
// sine, saw, pulse or noise) for every input word. It takes a word every cycle while
// the skid stage is empty; the sustained rate of one word per cycle is set by the
// 32-bit phase accumulator update, with the phase increment divided out ahead of it
// in three pipeline stages. A one-word skid stage behind the output register keeps
// s_axis_tready high while one sample waits. The user must write configuration through
// the cfg port only while no words are in flight; the block does not enforce this.
module multi_waveform_oscillator_unit #(
  parameter int SampleRate = mwo_pkg::SampleRateDef,
  parameter int SineDepth  = mwo_pkg::SineDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [47:0]                  s_axis_tdata,   // freq_hz [23:0], phase_in [47:24]
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [23:0]                  m_axis_tdata,   // sample_out [17:0], zero [23:18]
  input  logic                         cfg_we_i,
  input  logic [mwo_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [mwo_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import mwo_pkg::*;

  logic [2:0] wave_mode_q;
  logic       phase_ext_q;
  mwo_cfg_t   cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_mode_q <= WaveSine;
      phase_ext_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgWaveMode: wave_mode_q <= cfg_wdata_i;
        CfgPhaseExt: phase_ext_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg.wave_mode = wave_mode_q;
  assign cfg.phase_ext = phase_ext_q;

  // The whole pipeline advances unless the skid stage already holds a word.
  logic     en;
  logic     skid_valid_q, out_valid_q;
  logic     v0_q;
  logic [23:0] freq_q, phase_q;
  mwo_in_t  in_q;
  mwo_inc_t inc;
  mwo_res_t res;
  logic [17:0] skid_q, out_q;
  logic     handoff;

  assign en            = !skid_valid_q;
  assign s_axis_tready = en;
  assign handoff       = en && res.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      freq_q  <= s_axis_tdata[23:0];
      phase_q <= s_axis_tdata[47:24];
    end
  end

  assign in_q = '{valid: v0_q, freq: freq_q, phase: phase_q};

  mwo_inc_div #(
    .SampleRate(SampleRate)
  ) u_inc_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .in_i  (in_q),
    .inc_o (inc)
  );

  mwo_wave_shaper #(
    .SineDepth(SineDepth)
  ) u_wave_shaper (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .cfg_i (cfg),
    .inc_i (inc),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && !m_axis_tready) begin
      if (handoff) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= handoff;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && !m_axis_tready) begin
      if (handoff) begin
        skid_q <= res.sample;
      end
    end else if (skid_valid_q) begin
      out_q <= skid_q;
    end else if (handoff) begin
      out_q <= res.sample;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_q};

  `ASSERT_CLK(a_skid_behind_out, skid_valid_q |-> out_valid_q,
              "skid word held while the output register is empty")
  `ASSERT_CLK(a_skid_kept, skid_valid_q && !m_axis_tready |=> skid_valid_q,
              "skid word dropped while the output was stalled")

endmodule

[rtl/core/mwo_inc_div.sv]
// Phase increment pipeline: |freq| * 2^24 / sample rate by reciprocal multiply.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mwo_inc_div #(
  parameter int SampleRate = mwo_pkg::SampleRateDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  mwo_pkg::mwo_in_t  in_i,
  output mwo_pkg::mwo_inc_t inc_o
);
  import mwo_pkg::*;

  localparam int SrW      = $clog2(SampleRate);
  // Keeps the reciprocal below 2^32; the first quotient then falls short by at most nine.
  localparam int DivShift = SrW + 7;
  localparam longint unsigned RecipFull = (64'd1 << (24 + DivShift)) / SampleRate;
  localparam logic [31:0] Recip = RecipFull[31:0];
  localparam int RemW    = SrW + 5;
  localparam int NumCorr = 15;
  localparam logic [RemW-1:0] SrRem = RemW'(SampleRate);

  // Stage 1: magnitude times reciprocal, external phase clamped.
  logic [23:0] mag;
  logic [55:0] prod_d, prod_q;
  logic [16:0] ph_clamp, ph1_q;
  logic        v1_q;

  always_comb begin
    mag    = in_i.freq[23] ? 24'(-in_i.freq) : 24'(in_i.freq);
    prod_d = mag * Recip;
    if (in_i.phase[23]) begin
      ph_clamp = '0;
    end else if (in_i.phase > 24'sd65536) begin
      ph_clamp = 17'(OneQ16);
    end else begin
      ph_clamp = in_i.phase[16:0];
    end
  end

  // Stage 2: trial quotient and the low bits of quotient times rate.
  logic [55:0]     q0_full;
  logic [31:0]     q0_q;
  logic [RemW-1:0] qsr_d, qsr_q;
  logic [16:0]     ph2_q;
  logic            v2_q;

  always_comb begin
    q0_full = prod_q >> DivShift;
    qsr_d   = q0_full[RemW-1:0] * SrRem;
  end

  // Stage 3: the low 24 bits of the numerator are zero, so the remainder is the
  // negated product, exact modulo 2^RemW. Count how many rates it still holds.
  logic [RemW-1:0] rem;
  logic [3:0]      corr;
  logic [31:0]     inc_d;

  always_comb begin
    rem  = -qsr_q;
    corr = '0;
    for (int j = 1; j <= NumCorr; j++) begin
      if (rem >= RemW'(j * SampleRate)) begin
        corr = corr + 4'd1;
      end
    end
    inc_d = q0_q + 32'(corr);
  end

  logic        v3_q;
  logic [31:0] inc_q;
  logic [16:0] ph3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      ph1_q  <= ph_clamp;
      q0_q   <= q0_full[31:0];
      qsr_q  <= qsr_d;
      ph2_q  <= ph1_q;
      inc_q  <= inc_d;
      ph3_q  <= ph2_q;
    end
  end

  assign inc_o = '{valid: v3_q, inc: inc_q, phase: ph3_q};

  // After correction no whole rate may remain in the remainder.
  `ASSERT_CLK(a_rem_reduced, v2_q |-> (rem - RemW'(corr) * SrRem) < SrRem,
              "increment remainder not fully reduced")

endmodule

[rtl/core/mwo_wave_shaper.sv]
// Phase accumulator, waveform shaping, sine ROM and noise LFSR.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mwo_wave_shaper #(
  parameter int SineDepth = mwo_pkg::SineDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  mwo_pkg::mwo_cfg_t cfg_i,
  input  mwo_pkg::mwo_inc_t inc_i,
  output mwo_pkg::mwo_res_t res_o
);
  import mwo_pkg::*;

  // The depth is a power of two, so the table index is a shift of the phase.
  localparam int Aw       = $clog2(SineDepth);
  localparam int IdxShift = 14 - Aw;

  typedef logic [SineDepth-1:0][16:0] rom_t;

  function automatic rom_t build_rom();
    rom_t t;
    for (int k = 0; k < SineDepth; k++) begin
      t[k] = sine_q16((PiHalfQ30 * 64'(k)) >> Aw);
    end
    return t;
  endfunction

  localparam rom_t SineRom = build_rom();

  // Stage 4: accumulate and pick the phase source.
  logic [31:0] accum_q, accum_sum;
  logic [16:0] p_d, p4_q;
  logic        v4_q;

  always_comb begin
    accum_sum = accum_q + inc_i.inc;
    p_d = cfg_i.phase_ext ? inc_i.phase : {1'b0, accum_sum[31:16]};
  end

  // Stage 5: ROM read and the table-free waveforms.
  logic [16:0]     idx;
  logic [2:0]      quad;
  logic [Aw-1:0]   r, rom_addr;
  logic [16:0]     rom_q;
  logic            peak_q, zero_q, neg_q, v5_q;
  logic [31:0]     lfsr_q, lfsr_nx;
  logic [17:0]     wave_d, wave_q;

  always_comb begin
    idx      = p4_q >> IdxShift;
    quad     = idx[Aw+2:Aw];
    r        = idx[Aw-1:0];
    rom_addr = quad[0] ? -r : r;
    lfsr_nx  = lfsr_q[0] ? ((lfsr_q >> 1) ^ LfsrTaps) : (lfsr_q >> 1);
    case (cfg_i.wave_mode)
      WaveRamp:  wave_d = {1'b0, p4_q};
      WaveSaw:   wave_d = 18'(OneQ16) - {p4_q, 1'b0};
      WavePulse: wave_d = (p4_q < 17'd32768) ? -18'(OneQ16) : 18'(OneQ16);
      WaveNoise: wave_d = 18'(OneQ16) - {1'b0, lfsr_nx[31:16], 1'b0};
      default:   wave_d = '0;
    endcase
  end

  // Stage 6: fold the quarter wave into the full period and select.
  logic [16:0]        sine_mag;
  logic signed [17:0] sine_val, y_d;

  always_comb begin
    sine_mag = peak_q ? 17'(OneQ16) : rom_q;
    if (zero_q) begin
      sine_val = '0;
    end else if (neg_q) begin
      sine_val = -$signed({1'b0, sine_mag});
    end else begin
      sine_val = $signed({1'b0, sine_mag});
    end
    y_d = (cfg_i.wave_mode == WaveSine) ? sine_val : $signed(wave_q);
  end

  logic               v6_q;
  logic signed [17:0] sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q <= '0;
      lfsr_q  <= LfsrSeed;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      v6_q    <= 1'b0;
    end else if (en_i) begin
      v4_q <= inc_i.valid;
      v5_q <= v4_q;
      v6_q <= v5_q;
      if (inc_i.valid && !cfg_i.phase_ext) begin
        accum_q <= accum_sum;
      end
      if (v4_q && cfg_i.wave_mode == WaveNoise) begin
        lfsr_q <= lfsr_nx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p4_q     <= p_d;
      rom_q    <= SineRom[rom_addr];
      peak_q   <= quad[0] && (r == '0);
      zero_q   <= quad[2];
      neg_q    <= quad[1];
      wave_q   <= wave_d;
      sample_q <= y_d;
    end
  end

  assign res_o = '{valid: v6_q, sample: sample_q};

  `ASSERT_NEVER(a_lfsr_live, lfsr_q == '0, "noise LFSR reached the all-zero lockup state")
  `ASSERT_CLK(a_sample_range,
              v6_q |-> (res_o.sample >= -18'sd65536 && res_o.sample <= 18'sd65536),
              "sample outside the Q1.16 range")

endmodule

[verif/tb_multi_waveform_oscillator_unit.sv]
// Testbench for the multi-waveform oscillator: random and directed words, checked against a predictor.
`timescale 1ns / 1ps

module tb_multi_waveform_oscillator_unit;
  import mwo_pkg::*;

  localparam int RateHz = 44100;
  localparam int TabDepth = 1024;
  localparam int FullScale = 65536;
  localparam logic [31:0] TapMask = 32'h8020_0003;
  localparam logic [31:0] LfsrInit = 32'h0000_ACE1;
  localparam longint unsigned PiQ30 = 64'd3373259426;
  localparam logic [2:0] WaveUndefLo = 3'd5;
  localparam logic [2:0] WaveUndefHi = 3'd7;
  localparam int NumPhases = 20;
  localparam int HoldCycles = 250;
  localparam int Settle = 12;

  typedef struct packed {
    logic signed [23:0] phase;
    logic signed [23:0] freq;
  } osc_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // freq_hz [23:0], phase_in [47:24]
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;       // sample_out [17:0], zero [23:18]
  logic cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  multi_waveform_oscillator_unit uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we_i(cfg_we_i),
    .cfg_addr_i(cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // Predictor state and its copy of the configuration.
  logic [2:0] mode_q = WaveSine;
  logic ext_q = 1'b0;
  logic [31:0] accum_q = '0;
  logic [31:0] lfsr_q = LfsrInit;
  logic [16:0] sine_tab [TabDepth];

  osc_word_t word_q[$];
  logic signed [17:0] sample_q[$];
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int fail_count = 0;
  int checked_count = 0;

  function automatic logic [16:0] quarter_sine(longint unsigned x);
    longint unsigned acc;
    longint unsigned term;
    acc = x;
    term = x;
    for (int n = 1; n <= 6; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = (acc >= term) ? acc - term : 64'd0;
      end else begin
        acc = acc + term;
      end
    end
    acc = (acc + 64'd8192) >> 14;
    if (acc > FullScale) begin
      acc = 64'(FullScale);
    end
    return acc[16:0];
  endfunction

  // Advances the predictor by one word and returns the sample it should produce.
  function automatic logic signed [17:0] next_sample(osc_word_t w);
    longint mag;
    longint unsigned step;
    logic [16:0] p;
    int y;
    int idx;
    int quad;
    int r;
    int t;
    if (ext_q) begin
      if (w.phase < 0) begin
        p = '0;
      end else if (w.phase > FullScale) begin
        p = 17'(FullScale);
      end else begin
        p = w.phase[16:0];
      end
    end else begin
      mag = longint'(w.freq);
      if (mag < 0) begin
        mag = -mag;
      end
      step = (longint'(mag) << 24) / RateHz;
      accum_q = accum_q + step[31:0];
      p = {1'b0, accum_q[31:16]};
    end
    case (mode_q)
      WaveRamp: y = int'(p);
      WaveSine: begin
        idx = (int'(p) * 4 * TabDepth) >> 16;
        quad = idx / TabDepth;
        r = idx % TabDepth;
        if (quad % 2 == 1) begin
          t = (r == 0) ? FullScale : int'(sine_tab[TabDepth - r]);
        end else begin
          t = int'(sine_tab[r]);
        end
        if (quad >= 4) begin
          y = 0;
        end else begin
          y = (quad >= 2) ? -t : t;
        end
      end
      WaveSaw: y = FullScale - 2 * int'(p);
      WavePulse: y = (p < 17'd32768) ? -FullScale : FullScale;
      WaveNoise: begin
        lfsr_q = lfsr_q[0] ? ((lfsr_q >> 1) ^ TapMask) : (lfsr_q >> 1);
        y = FullScale - 2 * int'(lfsr_q[31:16]);
      end
      default: y = 0;
    endcase
    return y[17:0];
  endfunction

  // Word source: the prediction is made when a word is taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        sample_q.push_back(next_sample(osc_word_t'(s_axis_tdata)));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (word_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= word_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long sink hold, counted down in cycles once requested.
  always @(posedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HoldCycles;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Sample sink and checker, with the random stalls and the long hold.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        checked_count++;
        if (sample_q.size() == 0) begin
          $error("sample_out: no sample expected, actual %0d", $signed(m_axis_tdata[17:0]));
          fail_count++;
        end else begin
          if (m_axis_tdata[17:0] !== sample_q[0]) begin
            $error("sample_out: expected %0d, actual %0d", sample_q[0],
                   $signed(m_axis_tdata[17:0]));
            fail_count++;
          end
          void'(sample_q.pop_front());
        end
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic push_word(logic signed [23:0] freq, logic signed [23:0] phase);
    osc_word_t w;
    w.freq = freq;
    w.phase = phase;
    word_q.push_back(w);
  endtask

  // Waits until every word is taken and every sample has come back.
  task automatic drain();
    while (word_q.size() != 0 || s_axis_tvalid || sample_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (addr == CfgWaveMode) begin
      mode_q = val;
    end else begin
      ext_q = val[0];
    end
  endtask

  function automatic logic signed [23:0] pick_freq();
    logic signed [23:0] f;
    case ($urandom_range(3))
      0: f = 24'($urandom());
      1: f = 24'($urandom_range(20 * 256, 20000 * 256));
      2: begin
        case ($urandom_range(3))
          0: f = 24'sh800000;
          1: f = 24'sh7FFFFF;
          2: f = '0;
          default: f = -24'sd1;
        endcase
      end
      default: f = 24'($urandom_range(0, 2000 * 256));
    endcase
    if ($urandom_range(1)) begin
      f = -f;
    end
    return f;
  endfunction

  function automatic logic signed [23:0] pick_phase();
    logic signed [23:0] p;
    case ($urandom_range(4))
      0: p = 24'($urandom());
      1, 2: p = 24'($urandom_range(0, FullScale));
      3: p = 24'(FullScale - 2 + $urandom_range(0, 4));
      default: begin
        case ($urandom_range(4))
          0: p = 24'sh800000;
          1: p = 24'sh7FFFFF;
          2: p = -24'sd1;
          3: p = 24'sd32767;
          default: p = 24'sd32768;
        endcase
      end
    endcase
    return p;
  endfunction

  initial begin
    #(4_800_000);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    logic [2:0] wave;
    int count;
    for (int k = 0; k < TabDepth; k++) begin
      sine_tab[k] = quarter_sine((PiQ30 / 2) * longint'(k) / TabDepth);
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset configuration: sine from the internal accumulator.
    push_word(24'sd0, 24'sd0);
    push_word(24'sh7FFFFF, 24'sd0);
    push_word(24'sh800000, 24'sd0);
    push_word(-24'sd1, 24'sd0);
    drain();

    // External phase: clamping, then the shaping edges of the ramp, sine, saw and pulse waveforms.
    write_reg(CfgPhaseExt, 3'd1);
    write_reg(CfgWaveMode, WaveRamp);
    push_word(24'sd0, 24'sh800000);
    push_word(24'sd0, 24'sd0);
    push_word(24'sd0, 24'sd32768);
    push_word(24'sd0, 24'sd65535);
    push_word(24'sd0, 24'sd65536);
    push_word(24'sd0, 24'sh7FFFFF);
    drain();
    write_reg(CfgWaveMode, WaveSine);
    push_word(24'sd0, 24'sd16383);
    push_word(24'sd0, 24'sd16384);
    push_word(24'sd0, 24'sd32768);
    push_word(24'sd0, 24'sd49152);
    push_word(24'sd0, 24'sd65536);
    drain();
    write_reg(CfgWaveMode, WaveSaw);
    push_word(24'sd0, 24'sd0);
    push_word(24'sd0, 24'sd65536);
    drain();
    write_reg(CfgWaveMode, WavePulse);
    push_word(24'sd0, 24'sd32767);
    push_word(24'sd0, 24'sd32768);
    drain();

    // Noise, then an undefined mode that must leave the LFSR alone.
    write_reg(CfgPhaseExt, 3'd0);
    write_reg(CfgWaveMode, WaveNoise);
    repeat (3) push_word(24'sd1000, 24'sd0);
    drain();
    write_reg(CfgWaveMode, WaveUndefHi);
    repeat (2) push_word(24'sd1000, 24'sd0);
    drain();

    for (int ph = 0; ph < NumPhases; ph++) begin
      wave = 3'(ph % 8);
      write_reg(CfgWaveMode, wave);
      write_reg(CfgPhaseExt, {2'b00, 1'(((ph / 8) % 2))});
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 56; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 56; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      count = (wave >= WaveUndefLo) ? 30 : 105;
      for (int i = 0; i < count; i++) begin
        push_word(pick_freq(), pick_phase());
      end
      // A long sink stall while words keep coming backs the pipeline up.
      if (ph % 6 == 2) begin
        hold_requests++;
      end
      drain();
      idle_pct = 0;
      stall_pct = 0;
    end

    $display("Checked %0d samples across all eight wave mode codes,", checked_count);
    $display("internal and external phase, clamping edges, idle and long stall patterns.");
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
